// ===== hw/rtl/gfst_pkg.sv =====
// Package for the gyro frame step trigger: frame byte codes, parser phases,
// register indexes and port widths. No dependencies.
package gfst_pkg;

  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned COUNT_W     = 4;

  localparam logic [7:0] HDR_FIRST  = 8'h50;
  localparam logic [7:0] HDR_SECOND = 8'h03;
  localparam logic [7:0] TYPE_XYZ   = 8'h03;

  // Threshold default is 183 * 5.
  localparam logic [15:0] THRESHOLD_RESET = 16'd915;
  localparam logic        INVERT_RESET    = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_STEP_THRESHOLD   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_INVERT_DIRECTION = CFG_INDEX_W'(1);

  typedef enum logic [4:0] {
    PH_HUNT0   = 5'b00001,
    PH_HUNT1   = 5'b00010,
    PH_TYPE    = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_SKIP    = 5'b10000
  } phase_t;

endpackage

// ===== hw/rtl/gyro_frame_step_trigger_unit.sv =====
// Gyro frame step trigger: byte-stream frame parser with reference-based
// step decision. Depends on gfst_pkg.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   rx      | rx_valid rx_ready rx_byte[7:0]            | in
//   result  | out_valid out_ready x_value[15:0]         | out
//           | step_now step_direction                   |
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data    | in
//
// One item per cycle sustained while results are taken. Each byte is held in
// an input register, then parsed and, on the last payload byte, decided in
// one pass into the result register.
// Reset (rst, synchronous) returns the parser to the header hunt, drops the
// reference and reloads the register defaults.
// A result waiting in the output register holds the input stage only when
// the input stage has a byte ready to move; otherwise bytes keep flowing.
module gyro_frame_step_trigger_unit
  import gfst_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = 8,
  parameter int unsigned SKIP_BYTES    = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rx_valid,
  output logic                   rx_ready,
  input  logic [7:0]             rx_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [15:0]            x_value,
  output logic                   step_now,
  output logic                   step_direction,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [COUNT_W-1:0] PAYLOAD_LAST = COUNT_W'(PAYLOAD_BYTES);
  localparam logic [COUNT_W-1:0] SKIP_LEN     = COUNT_W'(SKIP_BYTES);

  // Configuration registers
  logic [15:0] step_threshold;
  logic        invert_direction;

  // Input stage
  logic       in_full;
  logic [7:0] in_byte;
  logic       advance;

  // Parser state
  phase_t             parse_phase, parse_phase_next;
  logic [COUNT_W-1:0] byte_count, byte_count_next, count_inc;
  logic [7:0]         high_byte, high_byte_next;
  logic [7:0]         value_low_byte, value_low_byte_next;
  logic [15:0]        reference_value;
  logic               calibrated;

  // Decision path
  logic        frame_done;
  logic [15:0] x_cur, ref_cur;
  logic [16:0] diff, mag;
  logic        step_cur, dir_cur;

  assign cfg_ready = 1'b1;
  assign advance   = in_full && (!out_valid || out_ready);
  assign rx_ready  = !in_full || advance;
  assign count_inc = byte_count + COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_threshold   <= THRESHOLD_RESET;
      invert_direction <= INVERT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_STEP_THRESHOLD) begin
        step_threshold <= cfg_data;
      end else if (cfg_index == REG_INVERT_DIRECTION) begin
        invert_direction <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (rx_ready) begin
      in_full <= rx_valid;
    end
    if (rx_ready && rx_valid) begin
      in_byte <= rx_byte;
    end
  end

  // Walk the frame: header hunt, type byte, then payload or skip.
  always_comb begin
    parse_phase_next    = parse_phase;
    byte_count_next     = byte_count;
    high_byte_next      = high_byte;
    value_low_byte_next = value_low_byte;
    frame_done          = 1'b0;
    case (parse_phase)
      PH_HUNT0: begin
        if (in_byte == HDR_FIRST) parse_phase_next = PH_HUNT1;
      end
      PH_HUNT1: begin
        parse_phase_next = (in_byte == HDR_SECOND) ? PH_TYPE : PH_HUNT0;
      end
      PH_TYPE: begin
        byte_count_next = '0;
        if (in_byte == TYPE_XYZ) begin
          parse_phase_next = PH_PAYLOAD;
        end else begin
          parse_phase_next = (SKIP_BYTES > 0) ? PH_SKIP : PH_HUNT0;
        end
      end
      PH_SKIP: begin
        byte_count_next = count_inc;
        if (count_inc >= SKIP_LEN) begin
          byte_count_next  = '0;
          parse_phase_next = PH_HUNT0;
        end
      end
      PH_PAYLOAD: begin
        if (byte_count == COUNT_W'(0)) high_byte_next = in_byte;
        if (byte_count == COUNT_W'(1)) value_low_byte_next = in_byte;
        byte_count_next = count_inc;
        if (count_inc >= PAYLOAD_LAST) begin
          byte_count_next  = '0;
          parse_phase_next = PH_HUNT0;
          frame_done       = 1'b1;
        end
      end
      default: begin
        parse_phase_next = PH_HUNT0;
      end
    endcase
  end

  // First frame becomes the reference, so its deviation is zero.
  always_comb begin
    x_cur    = {high_byte_next, value_low_byte_next};
    ref_cur  = calibrated ? reference_value : x_cur;
    diff     = {1'b0, ref_cur} - {1'b0, x_cur};
    mag      = diff[16] ? (17'd0 - diff) : diff;
    step_cur = mag > {1'b0, step_threshold};
    dir_cur  = step_cur && ((!diff[16] && (diff != 17'd0)) ^ invert_direction);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_HUNT0;
      byte_count      <= '0;
      high_byte       <= '0;
      value_low_byte  <= '0;
      reference_value <= '0;
      calibrated      <= 1'b0;
    end else if (advance) begin
      parse_phase    <= parse_phase_next;
      byte_count     <= byte_count_next;
      high_byte      <= high_byte_next;
      value_low_byte <= value_low_byte_next;
      if (frame_done && !calibrated) begin
        reference_value <= x_cur;
        calibrated      <= 1'b1;
      end
    end
  end

  // Result register: load on a finished frame, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= frame_done;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance && frame_done) begin
      x_value        <= x_cur;
      step_now       <= step_cur;
      step_direction <= dir_cur;
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Testbench for gyro_frame_step_trigger_unit: drives frame byte streams and
// register writes, and predicts every X value and step decision to check them.
// Depends on gfst_pkg and the unit under test; reads no files.
module testbench
  import gfst_pkg::*;
();

  localparam int unsigned PAYLOAD_LEN  = 8;
  localparam int unsigned SKIP_LEN     = 5;
  // Acceptance to visible result passes the input and result registers; allow a little more.
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned HOLDOFF_LEN  = 300;
  localparam int unsigned PHASE_BYTES  = 230;

  typedef struct packed {
    logic [15:0] x_value;
    logic        step_now;
    logic        step_direction;
  } step_decision_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   rx_valid = 1'b0;
  logic                   rx_ready;
  logic [7:0]             rx_byte = 8'h00;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [15:0]            x_value;
  logic                   step_now;
  logic                   step_direction;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  gyro_frame_step_trigger_unit #(
    .PAYLOAD_BYTES (PAYLOAD_LEN),
    .SKIP_BYTES    (SKIP_LEN)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .rx_valid       (rx_valid),
    .rx_ready       (rx_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .x_value        (x_value),
    .step_now       (step_now),
    .step_direction (step_direction),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bytes waiting to be offered, and step decisions waiting to come out.
  logic [7:0]     rx_bytes_pending[$];
  step_decision_t step_decisions_due[$];

  int unsigned bytes_queued   = 0;
  int unsigned bytes_accepted = 0;
  int unsigned fail_count     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned holdoff_left   = 0;
  logic        rx_fire        = 1'b0;

  // Shadow of the parser and the registers.
  phase_t      frame_phase   = PH_HUNT0;
  logic [3:0]  frame_count   = '0;
  logic [7:0]  x_high        = '0;
  logic [7:0]  x_low         = '0;
  logic [15:0] anchor_x      = '0;
  logic        anchor_locked = 1'b0;
  logic [15:0] cfg_threshold = THRESHOLD_RESET;
  logic        cfg_invert    = INVERT_RESET;

  // Advance the shadow parser by one byte; queue a decision on the last
  // payload byte.
  function automatic void parse_rx_byte(input logic [7:0] b);
    step_decision_t dec;
    int diff;
    int mag;
    case (frame_phase)
      PH_HUNT0: begin
        if (b == HDR_FIRST) frame_phase = PH_HUNT1;
      end
      PH_HUNT1: begin
        frame_phase = (b == HDR_SECOND) ? PH_TYPE : PH_HUNT0;
      end
      PH_TYPE: begin
        frame_count = '0;
        if (b == TYPE_XYZ) frame_phase = PH_PAYLOAD;
        else frame_phase = (SKIP_LEN > 0) ? PH_SKIP : PH_HUNT0;
      end
      PH_SKIP: begin
        frame_count = frame_count + 4'd1;
        if (frame_count >= SKIP_LEN) begin
          frame_count = '0;
          frame_phase = PH_HUNT0;
        end
      end
      PH_PAYLOAD: begin
        if (frame_count == 4'd0) x_high = b;
        else if (frame_count == 4'd1) x_low = b;
        frame_count = frame_count + 4'd1;
        if (frame_count >= PAYLOAD_LEN) begin
          frame_count = '0;
          frame_phase = PH_HUNT0;
          dec.x_value = {x_high, x_low};
          // The first payload becomes the reference and never steps.
          if (!anchor_locked) begin
            anchor_x = dec.x_value;
            anchor_locked = 1'b1;
          end
          diff = int'(anchor_x) - int'(dec.x_value);
          mag = (diff < 0) ? -diff : diff;
          dec.step_now = 1'b0;
          dec.step_direction = 1'b0;
          if (mag > int'(cfg_threshold)) begin
            dec.step_now = 1'b1;
            dec.step_direction = (diff > 0) ^ cfg_invert;
          end
          step_decisions_due.push_back(dec);
        end
      end
      default: frame_phase = PH_HUNT0;
    endcase
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] %s", $realtime, msg);
  endfunction

  // Driver: hold the current byte until taken, then offer the next one
  // unless this cycle is an idle one.
  always @(negedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
    end else if (!rx_valid || rx_fire) begin
      if (rx_bytes_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        rx_byte  <= rx_bytes_pending.pop_front();
        rx_valid <= 1'b1;
      end else begin
        rx_valid <= 1'b0;
      end
    end
  end

  // Receiver: a requested hold-off wins over the random stall.
  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on each accepted byte, check each accepted result.
  always @(posedge clk) begin : monitor
    step_decision_t got;
    step_decision_t want;
    rx_fire = rx_valid && rx_ready;
    if (!rst) begin
      if (rx_fire) begin
        bytes_accepted++;
        parse_rx_byte(rx_byte);
      end
      if (out_valid && out_ready) begin
        got = '{x_value, step_now, step_direction};
        if (step_decisions_due.size() == 0) begin
          note_failure($sformatf("unexpected result x=%h step=%b dir=%b",
                                 got.x_value, got.step_now, got.step_direction));
        end else begin
          want = step_decisions_due.pop_front();
          if (got.x_value !== want.x_value || got.step_now !== want.step_now ||
              got.step_direction !== want.step_direction)
            note_failure($sformatf(
              "result mismatch: expected x=%h step=%b dir=%b, got x=%h step=%b dir=%b",
              want.x_value, want.step_now, want.step_direction,
              got.x_value, got.step_now, got.step_direction));
        end
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    rx_bytes_pending.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_xyz_frame(input logic [15:0] x);
    queue_byte(HDR_FIRST);
    queue_byte(HDR_SECOND);
    queue_byte(TYPE_XYZ);
    queue_byte(x[15:8]);
    queue_byte(x[7:0]);
    repeat (PAYLOAD_LEN - 2) queue_byte(8'($urandom));
  endtask

  task automatic queue_skip_frame(input logic [7:0] kind);
    queue_byte(HDR_FIRST);
    queue_byte(HDR_SECOND);
    queue_byte(kind);
    repeat (SKIP_LEN) queue_byte(8'($urandom));
  endtask

  // Aim a good share of X values at the threshold edges around the
  // reference, some at the range ends or at and just above the reference, the rest anywhere.
  function automatic logic [15:0] pick_x();
    int v;
    int d;
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      d = int'(cfg_threshold) + int'($urandom_range(0, 2)) - 1;
      v = $urandom_range(0, 1) ? int'(anchor_x) + d : int'(anchor_x) - d;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return 16'(v);
    end
    if (r < 50) begin
      case ($urandom_range(0, 3))
        0: return 16'h0000;
        1: return 16'hFFFF;
        2: return anchor_x;
        default: return anchor_x + 16'(1);
      endcase
    end
    return 16'($urandom);
  endfunction

  // Mostly well-formed frames; the rest skip frames, noise and broken headers.
  task automatic queue_traffic(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned r;
    logic [7:0]  kind;
    stop_at = bytes_queued + n_bytes;
    while (bytes_queued < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        queue_xyz_frame(pick_x());
      end else if (r < 80) begin
        do kind = 8'($urandom); while (kind == TYPE_XYZ);
        queue_skip_frame(kind);
      end else if (r < 90) begin
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            queue_byte(HDR_FIRST);
            do kind = 8'($urandom); while (kind == HDR_SECOND);
            queue_byte(kind);
          end
          1: begin
            // A repeated first header byte does not resync the hunt.
            queue_byte(HDR_FIRST);
            queue_byte(HDR_FIRST);
            queue_byte(HDR_SECOND);
          end
          default: queue_byte(HDR_FIRST);
        endcase
      end
    end
  endtask

  // Wait until every queued byte is taken and every decision has come out,
  // then let the pipeline settle.
  task automatic wait_idle();
    do @(negedge clk);
    while (bytes_accepted != bytes_queued || step_decisions_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    // Mirror the write; indexes past the register list are dropped.
    if (idx == REG_STEP_THRESHOLD) cfg_threshold = data;
    else if (idx == REG_INVERT_DIRECTION) cfg_invert = data[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Write both registers; junk in the upper invert bits must be masked off.
  task automatic configure(input logic [15:0] thr, input logic inv);
    logic [CFG_DATA_W-1:0] inv_word;
    inv_word = CFG_DATA_W'($urandom);
    inv_word[0] = inv;
    write_reg(REG_STEP_THRESHOLD, thr);
    write_reg(REG_INVERT_DIRECTION, inv_word);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset register values: calibrate at mid-scale,
    // drop a stray byte and a bad second header byte, skip a frame of
    // another type, then step on a full-scale value.
    set_idling(0, 0);
    queue_xyz_frame(16'h8000);
    queue_byte(HDR_FIRST);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_skip_frame(8'h00);
    queue_xyz_frame(16'hFFFF);
    wait_idle();

    // Writes past the register list must change nothing.
    write_reg(CFG_INDEX_W'(15), CFG_DATA_W'($urandom));
    write_reg(CFG_INDEX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom));

    configure(16'h0000, 1'b0);
    set_idling(0, 0);
    queue_xyz_frame(16'h0000);
    queue_traffic(PHASE_BYTES);
    wait_idle();

    configure(16'hFFFF, 1'b1);
    set_idling(78, 0);
    queue_traffic(PHASE_BYTES);
    wait_idle();

    configure(16'($urandom_range(0, 2000)), 1'b0);
    set_idling(0, 78);
    queue_traffic(PHASE_BYTES);
    wait_idle();

    configure(THRESHOLD_RESET, 1'b1);
    set_idling(36, 36);
    queue_traffic(PHASE_BYTES);
    wait_idle();

    // Back-pressure: hold the output off for a long stretch while frames
    // keep streaming in, so the unit fills and stalls its input.
    configure(16'($urandom_range(0, 4000)), 1'($urandom));
    set_idling(0, 0);
    @(posedge clk);
    holdoff_left = HOLDOFF_LEN;
    repeat (20) queue_xyz_frame(pick_x());
    queue_traffic(PHASE_BYTES);
    wait_idle();

    configure(16'($urandom_range(0, 300)), 1'($urandom));
    set_idling(36, 36);
    queue_traffic(PHASE_BYTES);
    wait_idle();

    if (fail_count == 0 && step_decisions_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run.
  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
